// ----- rtl/lee_pkg.sv -----
// Shared types and constants of the line editor with erase and kill.
package lee_pkg;

    localparam int LINE_DEPTH  = 64;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int FILL_W      = $clog2(LINE_DEPTH + 1);
    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] ERASE_RESET = 8'd35;
    localparam logic [CHAR_W-1:0] KILL_RESET  = 8'd64;
    localparam logic [CHAR_W-1:0] END_RESET   = 8'd10;

    typedef enum logic [1:0] {
        CFG_ERASE = 2'd0,
        CFG_KILL  = 2'd1,
        CFG_END   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ERASE  = 2'd1,
        OP_KILL   = 2'd2,
        OP_END    = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [CHAR_W-1:0] ch;
    } t_op;

endpackage

// ----- rtl/lee_front.sv -----
// Front end: holds the control characters and classifies each incoming character.
module lee_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [7:0]                 i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [lee_pkg::CHAR_W-1:0] i_s_axis_tdata,
    output logic                       o_push_valid,
    input  logic                       i_push_ready,
    output lee_pkg::t_op               o_push_op
);
    import lee_pkg::*;

    logic [CHAR_W-1:0] r_erase;
    logic [CHAR_W-1:0] r_kill;
    logic [CHAR_W-1:0] r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase <= ERASE_RESET;
            r_kill  <= KILL_RESET;
            r_end   <= END_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ERASE: r_erase <= i_cfg_wdata;
                CFG_KILL:  r_kill  <= i_cfg_wdata;
                CFG_END:   r_end   <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_comb begin
        o_push_op.ch = i_s_axis_tdata;
        if (i_s_axis_tdata == r_erase) begin
            o_push_op.kind = OP_ERASE;
        end else if (i_s_axis_tdata == r_kill) begin
            o_push_op.kind = OP_KILL;
        end else if (i_s_axis_tdata == r_end) begin
            o_push_op.kind = OP_END;
        end else begin
            o_push_op.kind = OP_APPEND;
        end
    end

    assign o_push_valid    = i_s_axis_tvalid;
    assign o_s_axis_tready = i_push_ready;

endmodule

// ----- rtl/lee_queue.sv -----
// Short queue of classified operations between the front and back ends.
module lee_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  lee_pkg::t_op i_push_op,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output lee_pkg::t_op o_pop_op
);
    import lee_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");
    a_full_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_wr == r_rd))
        else $error("full queue with unequal pointers");
`endif

endmodule

// ----- rtl/lee_back.sv -----
// Back end: line store, fill count, line drain and output buffer.
module lee_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_op_valid,
    output logic                       o_op_ready,
    input  lee_pkg::t_op               i_op,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [lee_pkg::CHAR_W-1:0] o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);
    import lee_pkg::*;

    localparam int OB_DEPTH = 2;

    logic [CHAR_W-1:0] r_line [LINE_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_draining;
    logic              n_draining;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [ADDR_W-1:0] n_rd_idx;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic [CHAR_W-1:0] r_rd_data;

    logic [CHAR_W-1:0] r_ob_data [OB_DEPTH];
    logic              r_ob_last [OB_DEPTH];
    logic              r_ob_wr;
    logic              r_ob_rd;
    logic [1:0]        r_ob_count;

    logic              op_take;
    logic              do_write;
    logic              issue;
    logic              issue_last;
    logic              ob_pop;

    assign o_op_ready      = !r_draining;
    assign op_take         = i_op_valid && o_op_ready;
    assign o_m_axis_tvalid = (r_ob_count != 2'd0);
    assign o_m_axis_tdata  = r_ob_data[r_ob_rd];
    assign o_m_axis_tlast  = r_ob_last[r_ob_rd];
    assign ob_pop          = o_m_axis_tvalid && i_m_axis_tready;
    assign issue           = r_draining
        && ((3'(r_ob_count) + 3'(r_rd_valid)) < (3'(OB_DEPTH) + 3'(ob_pop)));
    assign issue_last      = (({1'b0, r_rd_idx} + FILL_W'(1)) == r_fill);
    assign do_write        = op_take && (i_op.kind == OP_APPEND)
        && (r_fill < FILL_W'(LINE_DEPTH));

    always_comb begin
        n_fill     = r_fill;
        n_draining = r_draining;
        n_rd_idx   = r_rd_idx;
        if (issue) begin
            if (issue_last) begin
                n_draining = 1'b0;
                n_fill     = '0;
            end else begin
                n_rd_idx = r_rd_idx + ADDR_W'(1);
            end
        end else if (op_take) begin
            unique case (i_op.kind)
                OP_ERASE: begin
                    if (r_fill != '0) begin
                        n_fill = r_fill - FILL_W'(1);
                    end
                end
                OP_KILL: n_fill = '0;
                OP_END: begin
                    if (r_fill != '0) begin
                        n_draining = 1'b1;
                        n_rd_idx   = '0;
                    end
                end
                OP_APPEND: begin
                    if (do_write) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_line[r_fill[ADDR_W-1:0]] <= i_op.ch;
        end
        if (issue) begin
            r_rd_data <= r_line[r_rd_idx];
            r_rd_last <= issue_last;
        end
        if (r_rd_valid) begin
            r_ob_data[r_ob_wr] <= r_rd_data;
            r_ob_last[r_ob_wr] <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_draining <= 1'b0;
            r_rd_idx   <= '0;
            r_rd_valid <= 1'b0;
            r_ob_wr    <= 1'b0;
            r_ob_rd    <= 1'b0;
            r_ob_count <= 2'd0;
        end else begin
            r_fill     <= n_fill;
            r_draining <= n_draining;
            r_rd_idx   <= n_rd_idx;
            r_rd_valid <= issue;
            if (r_rd_valid) begin
                r_ob_wr <= ~r_ob_wr;
            end
            if (ob_pop) begin
                r_ob_rd <= ~r_ob_rd;
            end
            if (r_rd_valid && !ob_pop) begin
                r_ob_count <= r_ob_count + 2'd1;
            end else if (ob_pop && !r_rd_valid) begin
                r_ob_count <= r_ob_count - 2'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LINE_DEPTH))
        else $error("fill count beyond line depth");
    a_drain_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> ({1'b0, r_rd_idx} < r_fill))
        else $error("drain index beyond fill count");
    a_ob_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> ((r_ob_count != 2'd2) || ob_pop))
        else $error("output buffer overrun");
    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && issue_last) |=> (!r_draining && (r_fill == '0)))
        else $error("drain did not release the line");
`endif

endmodule

// ----- rtl/line_editor_erase_kill_core.sv -----
// Top level of the line editor with erase and kill characters.
//
//  group       dir  payload                          handshake
//  s_axis      in   tdata[7:0] in_char               tvalid/tready
//  m_axis      out  tdata[7:0] out_char, tlast       tvalid/tready
//  cfg         in   idx 0 erase, 1 kill, 2 end        we, no wait
//
// The front end takes one character per cycle while the queue has room.
// Append, erase and kill each take effect as the back end takes them; an end
// character on a line of N characters holds the back end for N store reads,
// each registered and then written to the output buffer that drives m_axis.
// Reset is synchronous; the line store is not cleared, the fill count is.
// A stall on the output side backs up through the queue to the input.
module line_editor_erase_kill_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [7:0]                 i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [lee_pkg::CHAR_W-1:0] i_s_axis_tdata,   // [7:0] in_char
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [lee_pkg::CHAR_W-1:0] o_m_axis_tdata,   // [7:0] out_char
    output logic                       o_m_axis_tlast
);
    import lee_pkg::*;

    logic push_valid;
    logic push_ready;
    t_op  push_op;
    logic pop_valid;
    logic pop_ready;
    t_op  pop_op;

    lee_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_push_valid    (push_valid),
        .i_push_ready    (push_ready),
        .o_push_op       (push_op)
    );

    lee_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_op    (push_op),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_op     (pop_op)
    );

    lee_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (pop_valid),
        .o_op_ready      (pop_ready),
        .i_op            (pop_op),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
